@@ hw/rtl/asr_pkg.sv @@
`timescale 1ns / 1ps

package asr_pkg;

  localparam int NUM_ACTIONS_DEF = 8;

  localparam int IN_W      = 24;
  localparam int OUT_W     = 88;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int REG_W     = 16;
  localparam int MUL_IN_W  = 18;
  localparam int PROD_W    = 36;
  localparam int ACC_W     = 37;
  localparam int F_W       = 52;
  localparam int NUM_W     = 32;
  localparam int QUOT_W    = 16;
  localparam int RSUM_W    = 19;

  localparam logic [REG_W-1:0] TONIC_RST   = 16'd5120;
  localparam logic [REG_W-1:0] MAX_RST     = 16'd64000;
  localparam logic [REG_W-1:0] HGAIN_RST   = 16'd8192;
  localparam logic [REG_W-1:0] IGAIN_RST   = 16'd6144;
  localparam logic [REG_W-1:0] URGENCY_RST = 16'd13107;
  localparam logic [REG_W-1:0] DECAY_RST   = 16'd58982;

  // 1.0 in Q2.14
  localparam int ONE_Q14 = 16384;
  // mean inhibition below 0.3 enters indirect mode
  localparam int IND_NUM = 3;
  localparam int IND_DEN = 10;
  // peak excitation below 0.1 leaves suppression
  localparam int QUIET_NUM = 1;
  localparam int QUIET_DEN = 10;
  // average rate above 3.0 x tonic enters hyperdirect, at or below 1.2 x tonic returns to baseline
  localparam int HYPER_MULT = 3;
  localparam int BASE_NUM   = 12;
  localparam int BASE_DEN   = 10;

  localparam logic [RSUM_W-1:0] RSUM_MAX  = 19'h7FFFF;
  localparam logic [QUOT_W-1:0] LEVEL_MAX = 16'hFFFF;
  // firing sums are scaled by 2^27 over Q8.8
  localparam logic signed [ACC_W-1:0] S_BIAS = 37'sd134217728;

  typedef enum logic [2:0] {
    OP_EXC_ELEM = 3'd0,
    OP_EXC_ALL  = 3'd1,
    OP_INH_ELEM = 3'd2,
    OP_STOP     = 3'd3,
    OP_TICK     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    MODE_BASE  = 2'd0,
    MODE_HYPER = 2'd1,
    MODE_IND   = 2'd2,
    MODE_SUPP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_TONIC   = 3'd0,
    REG_MAX     = 3'd1,
    REG_HGAIN   = 3'd2,
    REG_IGAIN   = 3'd3,
    REG_URGENCY = 3'd4,
    REG_DECAY   = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FILL,
    ST_E_MUL,
    ST_E_ACC,
    ST_RD,
    ST_RDW,
    ST_DEC_MUL,
    ST_DEC_WB,
    ST_EXC_WB,
    ST_T_ACC1,
    ST_T_ACC2,
    ST_F_LO,
    ST_F_LO_ACC,
    ST_F_HI_ACC,
    ST_F_CHK,
    ST_DIV_WAIT,
    ST_LVL_WR,
    ST_G_DIV,
    ST_G_WAIT,
    ST_GM_MUL,
    ST_GM_UPD,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [REG_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ hw/rtl/action_suppression_rate_unit.sv @@
`timescale 1ns / 1ps

// Action suppression rate unit. Element writes (excitation or inhibition of one
// action) return nothing. Global excitation sweeps the excitation store. An
// emergency stop sweeps the store, then uses one shared 18x18 multiplier and a
// 16-step restoring divider before it returns NUM_ACTIONS results. A tick walks
// the actions one at a time: per action it runs elapsed_ms decay steps on the
// shared multiplier and a division in the divider when the level does not
// saturate, then it does the average and mode update. Each result passes a read
// state and a load state, and waits while the output side does not take it.
// The input side is not ready until the last result of an item is in the
// output register. The excitation and inhibition stores read as cleared after
// reset; no warm-up is needed.
module action_suppression_rate_unit import asr_pkg::*; #(
  parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // action_index[2:0], value[18:3], elapsed_ms[22:19], zero[23]
  input  logic [IN_W-1:0]      s_tdata,
  // operation[2:0]
  input  logic [OP_W-1:0]      s_tuser,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // result_action[2:0], action_level[18:3], global_level[34:19], mode_now[36:35],
  // suppression_count[68:37], peak_rate[84:69], zero[87:85]
  output logic [OUT_W-1:0]     m_tdata,
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int AW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int LSUM_W = REG_W + AW;
  localparam logic [AW-1:0] CNT_LAST = AW'(NUM_ACTIONS - 1);
  localparam logic [22:0] SUM_LIM = 23'(NUM_ACTIONS * IND_NUM * ONE_Q14);

  state_t state, state_next;

  logic [REG_W-1:0] tonic, max_r, hgain, igain, urgency, decay;

  logic [REG_W-1:0] exc_mem [NUM_ACTIONS];
  logic [REG_W-1:0] inh_mem [NUM_ACTIONS];
  logic [REG_W-1:0] lvl_mem [NUM_ACTIONS];
  logic [NUM_ACTIONS-1:0] exc_vld, inh_vld;
  logic [REG_W-1:0] exc_q, inh_q, lvl_q;
  logic exc_vq, inh_vq;

  logic exc_we, inh_we;
  logic [AW-1:0] exc_wa;
  logic [REG_W-1:0] exc_wd;

  logic [AW-1:0] cnt;
  logic [3:0] kstep, ms_q;
  logic emg;
  logic [REG_W-1:0] val_q, e_reg, inh_reg, level, g_reg, mx;
  logic signed [ACC_W-1:0] s_acc;
  logic [F_W-1:0] f_acc;
  logic [LSUM_W-1:0] lsum;
  mode_t mode;
  logic [31:0] stop_cnt;
  logic [REG_W-1:0] peak, rmax;
  logic [RSUM_W-1:0] rsum;

  logic [OUT_W-1:0] out_data;
  logic out_last, out_load;

  logic [MUL_IN_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  div_req_t div_req;
  div_rsp_t div_rsp;

  op_t in_op;
  logic [2:0] in_idx;
  logic [REG_W-1:0] in_val;
  logic [3:0] in_ms;
  logic in_fire, in_range;
  logic [AW+2:0] idx_ext, act_ext;
  logic [AW-1:0] in_addr;

  logic [REG_W-1:0] rmax_next;
  logic [RSUM_W:0] rsum_add;
  logic [RSUM_W-1:0] rsum_next;
  logic [22:0] rs10;
  logic [19:0] mx10;
  logic inh_hi, s_pos, f_sat;
  logic [REG_W-1:0] dmag;
  logic [31:0] lhs;
  logic [33:0] base3;
  logic [35:0] lhs10, base12;

  assign in_op    = op_t'(s_tuser);
  assign in_idx   = s_tdata[2:0];
  assign in_val   = s_tdata[18:3];
  assign in_ms    = s_tdata[22:19];
  assign in_fire  = s_tvalid && s_tready;
  assign in_range = {29'b0, in_idx} < 32'(NUM_ACTIONS);
  assign idx_ext  = {{AW{1'b0}}, in_idx};
  assign in_addr  = idx_ext[AW-1:0];
  assign act_ext  = {3'b0, cnt};

  assign rmax_next = (in_val > rmax) ? in_val : rmax;
  assign rsum_add  = {1'b0, rsum} + {4'b0, in_val};
  assign rsum_next = rsum_add[RSUM_W] ? RSUM_MAX : rsum_add[RSUM_W-1:0];
  assign rs10      = 23'(rsum_next) * 23'(IND_DEN);
  assign mx10      = 20'(mx) * 20'(QUIET_DEN);

  assign inh_hi = inh_reg > 16'(ONE_Q14);
  assign dmag   = inh_hi ? inh_reg - 16'(ONE_Q14) : 16'(ONE_Q14) - inh_reg;
  assign s_pos  = (s_acc > 37'sd0) && (max_r != '0);
  assign f_sat  = f_acc >= {9'b0, max_r, 27'b0};

  assign lhs    = mul_p[31:0];
  assign base3  = 34'({tonic, 16'b0}) * 34'(HYPER_MULT);
  assign lhs10  = 36'(lhs) * 36'(BASE_DEN);
  assign base12 = 36'({tonic, 16'b0}) * 36'(BASE_NUM);

  asr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  asr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mul_a         = '0;
    mul_b         = '0;
    exc_we        = 1'b0;
    exc_wa        = cnt;
    exc_wd        = e_reg;
    inh_we        = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    s_tready      = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (in_op)
            OP_EXC_ELEM: begin
              exc_we = in_range;
              exc_wa = in_addr;
              exc_wd = in_val;
            end
            OP_EXC_ALL:  state_next = ST_FILL;
            OP_STOP:     state_next = ST_FILL;
            OP_INH_ELEM: inh_we = in_range;
            OP_TICK:     state_next = ST_RD;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        exc_we = 1'b1;
        exc_wd = val_q;
        if (cnt == CNT_LAST) begin
          state_next = emg ? ST_E_MUL : ST_IDLE;
        end
      end
      ST_E_MUL: begin
        mul_a      = {2'b0, val_q};
        mul_b      = {2'b0, hgain};
        state_next = ST_E_ACC;
      end
      ST_E_ACC:   state_next = ST_F_LO;
      ST_RD:      state_next = ST_RDW;
      ST_RDW:     state_next = (ms_q != 4'd0) ? ST_DEC_MUL : ST_EXC_WB;
      ST_DEC_MUL: begin
        mul_a      = {2'b0, e_reg};
        mul_b      = {2'b0, decay};
        state_next = ST_DEC_WB;
      end
      ST_DEC_WB:  state_next = ((kstep + 4'd1) == ms_q) ? ST_EXC_WB : ST_DEC_MUL;
      ST_EXC_WB: begin
        exc_we     = 1'b1;
        mul_a      = {2'b0, e_reg};
        mul_b      = {2'b0, hgain};
        state_next = ST_T_ACC1;
      end
      ST_T_ACC1: begin
        mul_a      = {2'b0, dmag};
        mul_b      = {2'b0, igain};
        state_next = ST_T_ACC2;
      end
      ST_T_ACC2:  state_next = ST_F_LO;
      ST_F_LO: begin
        if (s_pos) begin
          mul_a      = s_acc[17:0];
          mul_b      = {2'b0, tonic};
          state_next = ST_F_LO_ACC;
        end else begin
          state_next = ST_LVL_WR;
        end
      end
      ST_F_LO_ACC: begin
        mul_a      = s_acc[35:18];
        mul_b      = {2'b0, tonic};
        state_next = ST_F_HI_ACC;
      end
      ST_F_HI_ACC: state_next = ST_F_CHK;
      ST_F_CHK: begin
        if (f_sat) begin
          state_next = ST_LVL_WR;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = f_acc[42:11];
          div_req.den   = max_r;
          state_next    = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_LVL_WR;
        end
      end
      ST_LVL_WR: begin
        if (emg) begin
          state_next = ST_EMIT_RD;
        end else if (cnt == CNT_LAST) begin
          state_next = ST_G_DIV;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_G_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = {{(NUM_W-LSUM_W){1'b0}}, lsum};
        div_req.den   = 16'(NUM_ACTIONS);
        state_next    = ST_G_WAIT;
      end
      ST_G_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_GM_MUL;
        end
      end
      ST_GM_MUL: begin
        mul_a      = {2'b0, g_reg};
        mul_b      = {2'b0, max_r};
        state_next = ST_GM_UPD;
      end
      ST_GM_UPD:  state_next = ST_EMIT_RD;
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = (cnt == CNT_LAST) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (exc_we) begin
      exc_mem[exc_wa] <= exc_wd;
    end
    if (inh_we) begin
      inh_mem[in_addr] <= in_val;
    end
    if (state == ST_LVL_WR && !emg) begin
      lvl_mem[cnt] <= level;
    end
    exc_q  <= exc_mem[cnt];
    inh_q  <= inh_mem[cnt];
    lvl_q  <= lvl_mem[cnt];
    exc_vq <= exc_vld[cnt];
    inh_vq <= inh_vld[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tonic    <= TONIC_RST;
      max_r    <= MAX_RST;
      hgain    <= HGAIN_RST;
      igain    <= IGAIN_RST;
      urgency  <= URGENCY_RST;
      decay    <= DECAY_RST;
      exc_vld  <= '0;
      inh_vld  <= '0;
      mode     <= MODE_BASE;
      stop_cnt <= '0;
      peak     <= '0;
      rmax     <= '0;
      rsum     <= '0;
      cnt      <= '0;
      emg      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_TONIC:   tonic   <= cfg_data;
          REG_MAX:     max_r   <= cfg_data;
          REG_HGAIN:   hgain   <= cfg_data;
          REG_IGAIN:   igain   <= cfg_data;
          REG_URGENCY: urgency <= cfg_data;
          REG_DECAY:   decay   <= cfg_data;
          default:     tonic   <= tonic;
        endcase
      end
      if (exc_we) begin
        exc_vld[exc_wa] <= 1'b1;
      end
      if (inh_we) begin
        inh_vld[in_addr] <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_op)
              OP_EXC_ELEM: begin
                if (s_tlast) begin
                  if (rmax_next > urgency) begin
                    mode <= MODE_HYPER;
                  end
                  rmax <= '0;
                end else begin
                  rmax <= rmax_next;
                end
              end
              OP_EXC_ALL: begin
                cnt <= '0;
                emg <= 1'b0;
                if (in_val > urgency) begin
                  mode <= MODE_HYPER;
                end
              end
              OP_INH_ELEM: begin
                if (s_tlast) begin
                  if (rs10 < SUM_LIM && mode == MODE_BASE) begin
                    mode <= MODE_IND;
                  end
                  rsum <= '0;
                end else begin
                  rsum <= rsum_next;
                end
              end
              OP_STOP: begin
                cnt      <= '0;
                emg      <= 1'b1;
                mode     <= MODE_SUPP;
                stop_cnt <= stop_cnt + 32'd1;
              end
              OP_TICK: begin
                cnt <= '0;
                emg <= 1'b0;
              end
              default: cnt <= cnt;
            endcase
          end
        end
        ST_FILL: begin
          cnt <= (cnt == CNT_LAST) ? '0 : cnt + AW'(1);
        end
        ST_LVL_WR: begin
          cnt <= (emg || cnt == CNT_LAST) ? '0 : cnt + AW'(1);
        end
        ST_G_WAIT: begin
          if (div_rsp.done && mx10 < 20'(ONE_Q14 * QUIET_NUM) && mode == MODE_SUPP) begin
            mode <= MODE_BASE;
          end
        end
        ST_GM_UPD: begin
          if (mode != MODE_SUPP) begin
            if ({2'b0, lhs} > base3) begin
              mode <= MODE_HYPER;
            end else if (lhs10 <= base12) begin
              mode <= MODE_BASE;
            end
          end
          if (lhs[31:16] > peak) begin
            peak <= lhs[31:16];
          end
        end
        ST_EMIT_LD: begin
          if (out_load) begin
            cnt <= (cnt == CNT_LAST) ? '0 : cnt + AW'(1);
          end
        end
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          val_q <= in_val;
          ms_q  <= in_ms;
          mx    <= '0;
          lsum  <= '0;
        end
      end
      ST_RDW: begin
        e_reg   <= exc_vq ? exc_q : '0;
        inh_reg <= inh_vq ? inh_q : '0;
        kstep   <= 4'd0;
      end
      ST_DEC_WB: begin
        e_reg <= mul_p[31:16];
        kstep <= kstep + 4'd1;
      end
      ST_EXC_WB: begin
        if (e_reg > mx) begin
          mx <= e_reg;
        end
      end
      ST_T_ACC1: s_acc <= S_BIAS + $signed({4'b0, mul_p[31:0], 1'b0});
      ST_T_ACC2: begin
        if (inh_hi) begin
          s_acc <= s_acc - $signed({5'b0, mul_p[31:0]});
        end else begin
          s_acc <= s_acc + $signed({5'b0, mul_p[31:0]});
        end
      end
      // stop value term carries 4 x the weight of a tick excitation term, on the same 2^27 scale
      ST_E_ACC: s_acc <= S_BIAS + $signed({2'b0, mul_p[31:0], 3'b0});
      ST_F_LO: begin
        if (!s_pos) begin
          level <= '0;
        end
      end
      ST_F_LO_ACC: f_acc <= {16'b0, mul_p};
      ST_F_HI_ACC: f_acc <= f_acc + {mul_p[33:0], 18'b0};
      ST_F_CHK: begin
        if (f_sat) begin
          level <= LEVEL_MAX;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          level <= div_rsp.quot;
        end
      end
      ST_LVL_WR: begin
        if (emg) begin
          g_reg <= level;
        end else begin
          lsum <= lsum + {{AW{1'b0}}, level};
        end
      end
      ST_G_WAIT: begin
        if (div_rsp.done) begin
          g_reg <= div_rsp.quot;
        end
      end
      ST_EMIT_LD: begin
        if (out_load) begin
          out_data <= {3'b0, peak, stop_cnt, 2'(mode), g_reg,
                       (emg ? level : lvl_q), act_ext[2:0]};
          out_last <= (cnt == CNT_LAST);
        end
      end
      default: val_q <= val_q;
    endcase
  end

  assign m_tdata   = out_data;
  assign m_tlast   = out_last;
  assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
  a_stop_enters_supp: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_op == OP_STOP) |=> (mode == MODE_SUPP))
    else $error("emergency stop did not enter suppression");

  a_stop_counts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_op == OP_STOP) |=> (stop_cnt == $past(stop_cnt) + 32'd1))
    else $error("stop counter did not advance by one");

  a_peak_holds: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (peak >= $past(peak)))
    else $error("peak rate decreased");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule

@@ hw/rtl/asr_mul.sv @@
`timescale 1ns / 1ps

module asr_mul import asr_pkg::*; (
  input  logic                clk,
  input  logic [MUL_IN_W-1:0] a,
  input  logic [MUL_IN_W-1:0] b,
  output logic [PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ hw/rtl/asr_div.sv @@
`timescale 1ns / 1ps

module asr_div import asr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-2:0]  dsh;
  logic [QUOT_W-1:0] quot;
  logic [3:0]        step;
  logic              busy;
  logic              done;
  logic              fits;

  assign fits = {1'b0, dsh} <= rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 4'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 4'd15;
      end else if (busy) begin
        if (step == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      dsh <= {req.den, 15'b0};
    end else if (busy) begin
      if (fits) begin
        rem <= rem - {1'b0, dsh};
      end
      quot <= {quot[QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule
